>>> rtl/core/hmgm_pkg.sv
// hmgm_pkg: shared constants, register indexes and types of the heightmap mesh generator
// no dependencies; used by every file in rtl/core
`timescale 1ns / 1ps

package hmgm_pkg;

  // grid limits and field widths
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = $clog2(MaxDim);
  localparam int unsigned CfgDimW  = 13;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StepW    = 24;
  localparam int unsigned IdxW     = 24;
  localparam int unsigned XW       = 36;
  localparam int unsigned YW       = 40;
  localparam int unsigned TexW     = 17;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;

  // one quotient bit per divider step
  localparam int unsigned DivSteps = TexW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // queue between front and back
  localparam int unsigned DefaultQueueDepth = 4;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegGridWidth      = 2'd0;
  localparam logic [CfgAddrW-1:0] RegGridHeight     = 2'd1;
  localparam logic [CfgAddrW-1:0] RegHorizontalStep = 2'd2;
  localparam logic [CfgAddrW-1:0] RegHeightScale    = 2'd3;

  // register reset values
  localparam logic [CfgDimW-1:0] GridWidthRst      = 13'd256;
  localparam logic [CfgDimW-1:0] GridHeightRst     = 13'd256;
  localparam logic [StepW-1:0]   HorizontalStepRst = 24'd607257;
  localparam logic [StepW-1:0]   HeightScaleRst    = 24'd6554;

  // effective configuration seen by front and back
  typedef struct packed {
    logic [DimW-1:0]  wm1;    // clamped width minus one
    logic [DimW-1:0]  hm1;    // clamped height minus one
    logic [StepW-1:0] step;
    logic [StepW-1:0] scale;
  } cfg_t;

  // one classified word in the queue
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [DimW-1:0]    col;
    logic [DimW-1:0]    flip;
    logic               quad;
    logic [IdxW-1:0]    index_a;
  } entry_t;

endpackage

>>> rtl/core/hmgm_front.sv
// hmgm_front: raster position counters, cell classification and quad base index
// depends on hmgm_pkg
`timescale 1ns / 1ps

module hmgm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hmgm_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hmgm_pkg::SampleW-1:0]  height_sample_i,
  input  logic                          full_i,
  output logic                          push_o,
  output hmgm_pkg::entry_t              entry_o
);

  logic [hmgm_pkg::DimW-1:0] col_q, col_d, row_q, row_d;
  logic [hmgm_pkg::IdxW-1:0] base_q, base_d;
  logic [hmgm_pkg::DimW-1:0] col, row;
  logic [hmgm_pkg::IdxW-1:0] width_ext;
  logic                      fire;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;
  assign push_o     = fire;

  // full width of a row, for base index steps
  assign width_ext = hmgm_pkg::IdxW'(cfg_i.wm1) + hmgm_pkg::IdxW'(1);

  // counters past the grid count as the last column or row
  assign col = (col_q > cfg_i.wm1) ? cfg_i.wm1 : col_q;
  assign row = (row_q > cfg_i.hm1) ? cfg_i.hm1 : row_q;

  // classify the cell
  always_comb begin
    entry_o.sample  = height_sample_i;
    entry_o.col     = col;
    entry_o.flip    = cfg_i.hm1 - row;
    entry_o.quad    = (col < cfg_i.wm1) && (row < cfg_i.hm1);
    entry_o.index_a = base_q + hmgm_pkg::IdxW'(col);
  end

  // advance position, wrap after the last sample
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (fire) begin
      if (col_q >= cfg_i.wm1) begin
        col_d = '0;
        if (row_q >= cfg_i.hm1) begin
          row_d  = '0;
          base_d = '0;
        end else begin
          row_d  = row_q + hmgm_pkg::DimW'(1);
          base_d = base_q + width_ext;
        end
      end else begin
        col_d = col_q + hmgm_pkg::DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

endmodule

>>> rtl/core/hmgm_queue.sv
// hmgm_queue: short register queue of classified words between front and back
// depends on hmgm_pkg
`timescale 1ns / 1ps

module hmgm_queue #(
  parameter int unsigned Depth = hmgm_pkg::DefaultQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hmgm_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output hmgm_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hmgm_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/hmgm_back.sv
// hmgm_back: position products, texture coordinate divider and result register
// depends on hmgm_pkg
`timescale 1ns / 1ps

module hmgm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hmgm_pkg::cfg_t               cfg_i,
  input  logic                         empty_i,
  input  hmgm_pkg::entry_t             entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hmgm_pkg::XW-1:0]      x_position_o,
  output logic [hmgm_pkg::YW-1:0]      y_position_o,
  output logic [hmgm_pkg::XW-1:0]      z_position_o,
  output logic [hmgm_pkg::TexW-1:0]    tex_u_o,
  output logic [hmgm_pkg::TexW-1:0]    tex_v_o,
  output logic                         has_quad_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_a_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_b_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_c_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_d_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_e_o,
  output logic [hmgm_pkg::IdxW-1:0]    index_f_o
);

  localparam int unsigned RemW = hmgm_pkg::DimW + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [hmgm_pkg::DivCntW-1:0]    cnt_q;
  logic [RemW-1:0]                 ru_q, rv_q, du, dv, sub_u, sub_v;
  logic                            ge_u, ge_v;
  logic [hmgm_pkg::TexW-1:0]       qu_q, qv_q;
  logic [hmgm_pkg::XW-1:0]         x_q, z_q, prod_x, prod_z;
  logic [hmgm_pkg::YW-1:0]         y_q, prod_y;
  logic                            quad_q;
  logic [hmgm_pkg::IdxW-1:0]       idx_q, width_ext;
  logic                            load, step, emit, out_free;

  assign out_free  = !out_valid_o || out_ready_i;
  assign load      = (state_q == StIdle) && !empty_i;
  assign step      = (state_q == StDiv);
  assign emit      = (state_q == StDone) && out_free;
  assign pop_o     = load;
  assign width_ext = hmgm_pkg::IdxW'(cfg_i.wm1) + hmgm_pkg::IdxW'(1);

  // position products, registered on load
  assign prod_x = entry_i.col * cfg_i.step;
  assign prod_z = entry_i.flip * cfg_i.step;
  assign prod_y = entry_i.sample * cfg_i.scale;

  // one restoring divide step per cycle for both texture coordinates
  assign du    = {1'b0, cfg_i.wm1};
  assign dv    = {1'b0, cfg_i.hm1};
  assign ge_u  = (ru_q >= du);
  assign ge_v  = (rv_q >= dv);
  assign sub_u = ge_u ? ru_q - du : ru_q;
  assign sub_v = ge_v ? rv_q - dv : rv_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (load) state_d = StDiv;
      StDiv: begin
        if (cnt_q == hmgm_pkg::DivCntW'(hmgm_pkg::DivSteps - 1)) state_d = StDone;
      end
      StDone: if (emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + hmgm_pkg::DivCntW'(1);
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= prod_x;
      y_q    <= prod_y;
      z_q    <= prod_z;
      quad_q <= entry_i.quad;
      idx_q  <= entry_i.index_a;
      ru_q   <= RemW'(entry_i.col);
      rv_q   <= RemW'(entry_i.flip);
      qu_q   <= '0;
      qv_q   <= '0;
    end else if (step) begin
      ru_q <= {sub_u[hmgm_pkg::DimW-1:0], 1'b0};
      rv_q <= {sub_v[hmgm_pkg::DimW-1:0], 1'b0};
      qu_q <= {qu_q[hmgm_pkg::TexW-2:0], ge_u};
      qv_q <= {qv_q[hmgm_pkg::TexW-2:0], ge_v};
    end
  end

  // result register, indices zero without a quad
  always_ff @(posedge clk_i) begin
    if (emit) begin
      x_position_o <= x_q;
      y_position_o <= y_q;
      z_position_o <= z_q;
      tex_u_o      <= qu_q;
      tex_v_o      <= qv_q;
      has_quad_o   <= quad_q;
      index_a_o    <= quad_q ? idx_q : '0;
      index_b_o    <= quad_q ? idx_q + hmgm_pkg::IdxW'(1) : '0;
      index_c_o    <= quad_q ? idx_q + width_ext : '0;
      index_d_o    <= quad_q ? idx_q + hmgm_pkg::IdxW'(1) : '0;
      index_e_o    <= quad_q ? idx_q + width_ext + hmgm_pkg::IdxW'(1) : '0;
      index_f_o    <= quad_q ? idx_q + width_ext : '0;
    end
  end

endmodule

>>> rtl/core/heightmap_grid_mesh_generator.sv
// heightmap_grid_mesh_generator: top level, configuration registers and front/queue/back
// depends on hmgm_pkg, hmgm_front, hmgm_queue, hmgm_back
`timescale 1ns / 1ps

// Height samples enter in row-major order, one word per sample, and each gives one
// result word: vertex position, texture coordinates and, away from the last row and
// column, the six indices of the grid quad. The front counts raster position and
// accepts a sample per cycle while the queue (QueueDepth words) has room; the back
// takes one queued word at a time: a load step with the three position multiplies,
// restoring divide steps that produce both 17-bit texture coordinates one quotient
// bit at a time, and a step into the result register once it is free; that register
// lets the back start the next word while a result waits. The user must write the
// configuration registers only while no work is in flight; the block does not enforce it.

module heightmap_grid_mesh_generator #(
  parameter int unsigned QueueDepth = hmgm_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hmgm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [hmgm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hmgm_pkg::SampleW-1:0]  height_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hmgm_pkg::XW-1:0]       x_position_o,
  output logic [hmgm_pkg::YW-1:0]       y_position_o,
  output logic [hmgm_pkg::XW-1:0]       z_position_o,
  output logic [hmgm_pkg::TexW-1:0]     tex_u_o,
  output logic [hmgm_pkg::TexW-1:0]     tex_v_o,
  output logic                          has_quad_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_a_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_b_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_c_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_d_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_e_o,
  output logic [hmgm_pkg::IdxW-1:0]     index_f_o
);

  logic [hmgm_pkg::CfgDimW-1:0] grid_width_q, grid_height_q;
  logic [hmgm_pkg::StepW-1:0]   horizontal_step_q, height_scale_q;
  hmgm_pkg::cfg_t               cfg;
  hmgm_pkg::entry_t             push_entry, head_entry;
  logic                         push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q      <= hmgm_pkg::GridWidthRst;
      grid_height_q     <= hmgm_pkg::GridHeightRst;
      horizontal_step_q <= hmgm_pkg::HorizontalStepRst;
      height_scale_q    <= hmgm_pkg::HeightScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        hmgm_pkg::RegGridWidth:      grid_width_q <= cfg_wdata_i[hmgm_pkg::CfgDimW-1:0];
        hmgm_pkg::RegGridHeight:     grid_height_q <= cfg_wdata_i[hmgm_pkg::CfgDimW-1:0];
        hmgm_pkg::RegHorizontalStep: horizontal_step_q <= cfg_wdata_i[hmgm_pkg::StepW-1:0];
        hmgm_pkg::RegHeightScale:    height_scale_q <= cfg_wdata_i[hmgm_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions minus one
  function automatic logic [hmgm_pkg::DimW-1:0] dim_m1(
    input logic [hmgm_pkg::CfgDimW-1:0] v
  );
    logic [hmgm_pkg::CfgDimW-1:0] t;
    t = v - hmgm_pkg::CfgDimW'(1);
    if (v < hmgm_pkg::CfgDimW'(2)) begin
      return hmgm_pkg::DimW'(1);
    end else if (v > hmgm_pkg::CfgDimW'(hmgm_pkg::MaxDim)) begin
      return hmgm_pkg::DimW'(hmgm_pkg::MaxDim - 1);
    end
    return t[hmgm_pkg::DimW-1:0];
  endfunction

  always_comb begin
    cfg.wm1   = dim_m1(grid_width_q);
    cfg.hm1   = dim_m1(grid_height_q);
    cfg.step  = horizontal_step_q;
    cfg.scale = height_scale_q;
  end

  hmgm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .height_sample_i (height_sample_i),
    .full_i          (full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  hmgm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  hmgm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .x_position_o (x_position_o),
    .y_position_o (y_position_o),
    .z_position_o (z_position_o),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .has_quad_o   (has_quad_o),
    .index_a_o    (index_a_o),
    .index_b_o    (index_b_o),
    .index_c_o    (index_c_o),
    .index_d_o    (index_d_o),
    .index_e_o    (index_e_o),
    .index_f_o    (index_f_o)
  );

endmodule

>>> rtl/core/hmgm_checker.sv
// hmgm_checker: port-level assertions for the heightmap mesh generator, bound to the top
// depends on hmgm_pkg and heightmap_grid_mesh_generator
`timescale 1ns / 1ps

module hmgm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hmgm_pkg::XW-1:0]       x_position_o,
  input logic [hmgm_pkg::TexW-1:0]     tex_u_o,
  input logic [hmgm_pkg::TexW-1:0]     tex_v_o,
  input logic                          has_quad_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_a_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_b_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_c_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_d_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_e_o,
  input logic [hmgm_pkg::IdxW-1:0]     index_f_o
);

  // a result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_position_o) && $stable(index_a_o))
    else $error("result word dropped or changed while stalled");

  // texture coordinates never pass one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'h10000) && (tex_v_o <= 17'h10000))
    else $error("texture coordinate above one");

  // no quad means indices a, b, c and e are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_quad_o |-> (index_a_o == '0) && (index_b_o == '0) &&
      (index_c_o == '0) && (index_e_o == '0))
    else $error("indices set on a cell without quad");

  // the two triangles share their diagonal and neighbor corners
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_quad_o |-> (index_b_o == index_d_o) && (index_c_o == index_f_o) &&
      (index_b_o == index_a_o + 24'd1) && (index_e_o == index_c_o + 24'd1))
    else $error("quad indices inconsistent");

  // a result cannot appear right after reset without an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word out of reset");

endmodule

bind heightmap_grid_mesh_generator hmgm_checker u_hmgm_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: streams height samples through heightmap_grid_mesh_generator and checks every
// result word field by field against a predicted vertex, texture and quad index set
// depends on hmgm_pkg and heightmap_grid_mesh_generator

module testbench;
  import hmgm_pkg::*;

  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned HoldAfter     = 300;
  localparam int unsigned HoldMinLeft   = 20;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned RandomSamples = 1600;

  // one expected or observed result word
  typedef struct packed {
    logic [XW-1:0]   x_position;
    logic [YW-1:0]   y_position;
    logic [XW-1:0]   z_position;
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
    logic            has_quad;
    logic [IdxW-1:0] idx_a;
    logic [IdxW-1:0] idx_b;
    logic [IdxW-1:0] idx_c;
    logic [IdxW-1:0] idx_d;
    logic [IdxW-1:0] idx_e;
    logic [IdxW-1:0] idx_f;
  } vertex_t;

  // raster position tracker and queue of predicted vertices
  class mesh_scoreboard;
    logic [CfgDimW-1:0] width_reg;
    logic [CfgDimW-1:0] height_reg;
    logic [StepW-1:0]   step_reg;
    logic [StepW-1:0]   scale_reg;
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    logic [IdxW-1:0]    row_base;
    vertex_t            expected_q[$];
    int unsigned        fails;

    function new();
      width_reg  = GridWidthRst;
      height_reg = GridHeightRst;
      step_reg   = HorizontalStepRst;
      scale_reg  = HeightScaleRst;
      col_cnt    = 0;
      row_cnt    = 0;
      row_base   = '0;
      fails      = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegGridWidth:      width_reg  = data[CfgDimW-1:0];
        RegGridHeight:     height_reg = data[CfgDimW-1:0];
        RegHorizontalStep: step_reg   = data[StepW-1:0];
        RegHeightScale:    scale_reg  = data[StepW-1:0];
        default: ;
      endcase
    endfunction

    // out-of-range dimensions saturate to the legal span
    function longint unsigned dim_used(logic [CfgDimW-1:0] d);
      if (d < 2) return 2;
      if (d > MaxDim) return MaxDim;
      return 64'(d);
    endfunction

    function void note_sample(logic [SampleW-1:0] sample);
      longint unsigned w, h, col, row, flip, a;
      vertex_t v;
      w = dim_used(width_reg);
      h = dim_used(height_reg);
      // counters left past the grid by a smaller dimension act as the last column/row
      col  = (col_cnt > w - 1) ? w - 1 : col_cnt;
      row  = (row_cnt > h - 1) ? h - 1 : row_cnt;
      flip = h - 1 - row;

      v.x_position = XW'(col * longint'(step_reg));
      v.y_position = YW'(longint'(sample) * longint'(scale_reg));
      v.z_position = XW'(flip * longint'(step_reg));
      v.tex_u      = TexW'((col << 16) / (w - 1));
      v.tex_v      = TexW'((flip << 16) / (h - 1));
      v.has_quad   = (col < w - 1) && (row < h - 1);

      // quad indices wrap at the index width, zero when there is no quad
      if (v.has_quad) begin
        a = longint'(row_base) + col;
        v.idx_a = IdxW'(a);
        v.idx_b = IdxW'(a + 1);
        v.idx_c = IdxW'(a + w);
        v.idx_d = IdxW'(a + 1);
        v.idx_e = IdxW'(a + 1 + w);
        v.idx_f = IdxW'(a + w);
      end else begin
        v.idx_a = '0;
        v.idx_b = '0;
        v.idx_c = '0;
        v.idx_d = '0;
        v.idx_e = '0;
        v.idx_f = '0;
      end
      expected_q.insert(expected_q.size(), v);

      // advance raster position, wrapping after the last sample
      if (col_cnt >= w - 1) begin
        col_cnt = 0;
        if (row_cnt >= h - 1) begin
          row_cnt  = 0;
          row_base = '0;
        end else begin
          row_cnt  = row_cnt + 1;
          row_base = row_base + IdxW'(w);
        end
      end else begin
        col_cnt = col_cnt + 1;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 'h%0h want 'h%0h", name, got, want));
    endtask

    task check_vertex(vertex_t got);
      vertex_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with no sample pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("x_position", 64'(got.x_position), 64'(want.x_position));
      compare_field("y_position", 64'(got.y_position), 64'(want.y_position));
      compare_field("z_position", 64'(got.z_position), 64'(want.z_position));
      compare_field("tex_u", 64'(got.tex_u), 64'(want.tex_u));
      compare_field("tex_v", 64'(got.tex_v), 64'(want.tex_v));
      compare_field("has_quad", 64'(got.has_quad), 64'(want.has_quad));
      compare_field("index_a", 64'(got.idx_a), 64'(want.idx_a));
      compare_field("index_b", 64'(got.idx_b), 64'(want.idx_b));
      compare_field("index_c", 64'(got.idx_c), 64'(want.idx_c));
      compare_field("index_d", 64'(got.idx_d), 64'(want.idx_d));
      compare_field("index_e", 64'(got.idx_e), 64'(want.idx_e));
      compare_field("index_f", 64'(got.idx_f), 64'(want.idx_f));
    endtask
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i      = RegGridWidth;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  height_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [XW-1:0]       x_position_o;
  logic [YW-1:0]       y_position_o;
  logic [XW-1:0]       z_position_o;
  logic [TexW-1:0]     tex_u_o;
  logic [TexW-1:0]     tex_v_o;
  logic                has_quad_o;
  logic [IdxW-1:0]     index_a_o;
  logic [IdxW-1:0]     index_b_o;
  logic [IdxW-1:0]     index_c_o;
  logic [IdxW-1:0]     index_d_o;
  logic [IdxW-1:0]     index_e_o;
  logic [IdxW-1:0]     index_f_o;

  mesh_scoreboard sb;
  bit             steady = 1'b0;
  int unsigned    stall_cycles = 0;
  int unsigned    burst_left = 0;

  heightmap_grid_mesh_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .height_sample_i (height_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .x_position_o    (x_position_o),
    .y_position_o    (y_position_o),
    .z_position_o    (z_position_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .has_quad_o      (has_quad_o),
    .index_a_o       (index_a_o),
    .index_b_o       (index_b_o),
    .index_c_o       (index_c_o),
    .index_d_o       (index_d_o),
    .index_e_o       (index_e_o),
    .index_f_o       (index_f_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // register write, takes effect at the next edge
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // offer one sample word after a random gap and hold it until taken
  task automatic drive_sample(input logic [SampleW-1:0] sample);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    height_sample_i <= sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(sample);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain_burst();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // dimension data with random unused upper bits, mostly small grids
  function automatic logic [CfgDataW-1:0] pick_dim();
    int unsigned d;
    case ($urandom_range(0, 19))
      0:       d = $urandom_range(0, 1);
      1:       d = $urandom_range(MaxDim + 1, 8191);
      2:       d = MaxDim;
      3, 4, 5: d = $urandom_range(2, 64);
      default: d = $urandom_range(2, 9);
    endcase
    return {11'($urandom), 13'(d)};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // result side: random ready gaps, one long hold-off inside a long burst to back the block up
  initial begin : result_sink
    vertex_t     got;
    bit          held;
    int unsigned words_seen;
    int unsigned gap;
    held       = 1'b0;
    words_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (!held && words_seen >= HoldAfter && burst_left >= HoldMinLeft) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{x_position: x_position_o, y_position: y_position_o,
              z_position: z_position_o, tex_u: tex_u_o, tex_v: tex_v_o,
              has_quad: has_quad_o, idx_a: index_a_o, idx_b: index_b_o,
              idx_c: index_c_o, idx_d: index_d_o, idx_e: index_e_o,
              idx_f: index_f_o};
      sb.check_vertex(got);
      words_seen++;
    end
  end

  // stimulus
  initial begin : sample_source
    int unsigned n_items;
    int unsigned burst;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, sample extremes
    drive_sample(16'h0000);
    drive_sample(16'hffff);
    drive_sample(16'h0001);
    drive_sample(16'h8000);
    drain_burst();

    // dimensions below two saturate, column left past the narrower grid
    write_reg(RegGridWidth, 24'h000000);
    write_reg(RegGridHeight, 24'h000001);
    write_reg(RegHorizontalStep, 24'hffffff);
    write_reg(RegHeightScale, 24'hffffff);
    cfg_we_i <= 1'b0;
    drive_sample(16'hffff);
    drive_sample(16'h0000);
    drive_sample(16'h1234);
    drive_sample(16'hffff);
    drive_sample(16'h8001);
    drive_sample(16'h7ffe);
    drain_burst();

    // dimensions above the maximum saturate, zero scales
    write_reg(RegGridWidth, 24'hffffff);
    write_reg(RegGridHeight, 24'd5000);
    write_reg(RegHorizontalStep, 24'h000000);
    write_reg(RegHeightScale, 24'h000000);
    cfg_we_i <= 1'b0;
    drive_sample(16'h5555);
    drive_sample(16'haaaa);
    drive_sample(16'hffff);
    drain_burst();

    // shrink the grid under a running column count
    write_reg(RegGridWidth, 24'd3);
    write_reg(RegGridHeight, 24'd3);
    write_reg(RegHorizontalStep, 24'd1);
    write_reg(RegHeightScale, 24'd1);
    cfg_we_i <= 1'b0;
    repeat (5) drive_sample(pick_sample());
    drain_burst();

    // random bursts, each under a fresh partial reconfiguration
    n_items = 0;
    while (n_items < RandomSamples) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(RegGridWidth, pick_dim());
      if ($urandom_range(0, 1)) write_reg(RegGridHeight, pick_dim());
      if ($urandom_range(0, 1)) write_reg(RegHorizontalStep, pick_scale());
      if ($urandom_range(0, 1)) write_reg(RegHeightScale, pick_scale());
      cfg_we_i <= 1'b0;
      burst = $urandom_range(8, 60);
      burst_left = burst;
      while (burst_left != 0) begin
        drive_sample(pick_sample());
        burst_left--;
      end
      n_items += burst;
      drain_burst();
    end

    // let any stray word show up before closing
    steady = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
